// ===== design/srf_pkg.sv =====
// Shared types, sizes and codes of the square image rotate/flip block.
package srf_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int PIXEL_BITS = 16;

  localparam int SIDE_W    = $clog2(MAX_SIDE);             // row / column index
  localparam int N_W       = $clog2(MAX_SIDE + 1);         // side value 1..MAX_SIDE
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int POS_W     = $clog2(DEPTH);                // linear position
  localparam int TOT_W     = POS_W + 1;                    // pixel count N*N
  localparam int STEP_W    = $clog2(POS_W);
  localparam int SIDE_CFG_W = 7;
  localparam int MODE_W     = 3;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // register index (paddr[2])
  localparam logic REG_SIDE = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = SIDE_CFG_W'(64);

  // transform codes
  localparam logic [MODE_W-1:0] MODE_IDENT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLIPV  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FLIPH  = 3'd5;

  // request action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [PIXEL_BITS-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  last_of_image;
  } out_item_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quo;
    logic [N_W-1:0]   rem;
  } div_res_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'b01,
    DIV_RUN  = 2'b10
  } div_state_t;

endpackage

// ===== design/srf_pixel_ram.sv =====
// Pixel store: one write port, one read port with registered read data.
module srf_pixel_ram (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [srf_pkg::POS_W-1:0]      wr_addr,
  input  logic [srf_pkg::PIXEL_BITS-1:0] wr_data,
  input  logic                           rd_en,
  input  logic [srf_pkg::POS_W-1:0]      rd_addr,
  output logic [srf_pkg::PIXEL_BITS-1:0] rd_data
);
  import srf_pkg::*;

  logic [PIXEL_BITS-1:0] mem_r [DEPTH];
  logic [PIXEL_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/srf_divider.sv =====
// Restoring divider that splits a linear read position into row and column.
module srf_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [srf_pkg::POS_W-1:0] dividend,
  input  logic [srf_pkg::N_W-1:0]   divisor,
  output logic                      busy,
  output srf_pkg::div_res_t         res
);
  import srf_pkg::*;

  div_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [N_W:0]      rem_r, rem_nxt;
  logic [POS_W-1:0]  quo_r, quo_nxt;
  logic              done_r, done_nxt;
  logic [N_W:0]      trial;
  logic              ge;

  assign trial = {rem_r[N_W-1:0], quo_r[POS_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    if (start) begin
      state_nxt = DIV_RUN;
      step_nxt  = '0;
      rem_nxt   = '0;
      quo_nxt   = dividend;
    end else begin
      case (state_r)
        DIV_RUN: begin
          rem_nxt  = ge ? (trial - {1'b0, divisor}) : trial;
          quo_nxt  = {quo_r[POS_W-2:0], ge};
          step_nxt = step_r + STEP_W'(1);
          if (step_r == STEP_W'(POS_W - 1)) begin
            state_nxt = DIV_IDLE;
            done_nxt  = 1'b1;
          end
        end
        default: begin
          state_nxt = DIV_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign busy     = (state_r == DIV_RUN) || done_r;
  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r[N_W-1:0];

endmodule

// ===== design/srf_position.sv =====
// Write and read position counters and the transformed source address.
module srf_position (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [srf_pkg::N_W-1:0]     n_eff,
  input  logic [srf_pkg::MODE_W-1:0]  mode,
  input  logic                        wr_fire,
  input  logic                        rd_fire,
  input  logic                        resync_start,
  input  srf_pkg::div_res_t           div_res,
  output logic [srf_pkg::POS_W-1:0]   wr_addr,
  output logic [srf_pkg::POS_W-1:0]   rd_addr,
  output logic                        rd_last,
  output logic [srf_pkg::POS_W-1:0]   div_dividend,
  output logic [srf_pkg::TOT_W-1:0]   total
);
  import srf_pkg::*;

  logic [POS_W-1:0]   wpos_r, wpos_nxt, rpos_r, rpos_nxt;
  logic [SIDE_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [2*N_W-1:0]   sq;
  logic [POS_W-1:0]   wpos_use, rpos_clamp;
  logic [TOT_W-1:0]   wpos_inc, rpos_inc;
  logic [SIDE_W-1:0]  nm1, row_inv, col_inv, sr, sc;
  logic [POS_W-1:0]   sr_ext, n_ext, prod;

  assign sq    = (2*N_W)'(n_eff) * (2*N_W)'(n_eff);
  assign total = sq[TOT_W-1:0];
  assign nm1   = SIDE_W'(n_eff - N_W'(1));

  // a position left beyond the image by a smaller side restarts at zero
  assign wpos_use   = ({1'b0, wpos_r} >= total) ? '0 : wpos_r;
  assign rpos_clamp = ({1'b0, rpos_r} >= total) ? '0 : rpos_r;
  assign wpos_inc   = TOT_W'(wpos_use) + TOT_W'(1);
  assign rpos_inc   = TOT_W'(rpos_r) + TOT_W'(1);

  assign wr_addr      = wpos_use;
  assign div_dividend = rpos_clamp;
  assign rd_last      = (rpos_inc == total);

  always_comb begin
    wpos_nxt = wpos_r;
    if (wr_fire) begin
      wpos_nxt = (wpos_inc >= total) ? '0 : wpos_inc[POS_W-1:0];
    end
  end

  always_comb begin
    rpos_nxt = rpos_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (resync_start) begin
      rpos_nxt = rpos_clamp;
    end else if (div_res.done) begin
      row_nxt = div_res.quo[SIDE_W-1:0];
      col_nxt = div_res.rem[SIDE_W-1:0];
    end else if (rd_fire) begin
      if (rpos_inc >= total) begin
        rpos_nxt = '0;
        row_nxt  = '0;
        col_nxt  = '0;
      end else begin
        rpos_nxt = rpos_inc[POS_W-1:0];
        if (col_r == nm1) begin
          col_nxt = '0;
          row_nxt = row_r + SIDE_W'(1);
        end else begin
          col_nxt = col_r + SIDE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      rpos_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      wpos_r <= wpos_nxt;
      rpos_r <= rpos_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  assign row_inv = nm1 - row_r;
  assign col_inv = nm1 - col_r;

  always_comb begin
    case (mode)
      MODE_ROT90: begin
        sr = col_r;   sc = row_inv;
      end
      MODE_ROT180: begin
        sr = row_inv; sc = col_inv;
      end
      MODE_ROT270: begin
        sr = col_inv; sc = row_r;
      end
      MODE_FLIPV: begin
        sr = row_inv; sc = col_r;
      end
      MODE_FLIPH: begin
        sr = row_r;   sc = col_inv;
      end
      default: begin
        sr = row_r;   sc = col_r;
      end
    endcase
  end

  assign sr_ext  = POS_W'(sr);
  assign n_ext   = POS_W'(n_eff);
  assign prod    = sr_ext * n_ext;
  assign rd_addr = prod + POS_W'(sc);

endmodule

// ===== design/square_image_rotate_flip.sv =====
// Top level of the square image rotate/flip block.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in_      | in_valid / in_stall    | in_item_t  {action, pixel_in}
//   out_     | out_valid / out_stall  | out_item_t {pixel_out, last_of_image}
//   config   | psel/penable/pwrite    | paddr 0: side_length, 4: transform_mode
//
// One request per cycle while in_stall is low: the source address (one
// multiply and add) is formed and the pixel memory read in the accept cycle;
// the read register then feeds the output register. A write of side_length
// re-derives row and column of the read position in a 12-step divider, holding
// in_stall meanwhile. Reset clears both positions and loads side 64, identity.
// A stalled output backs up one read stage, then in_stall rises.
module square_image_rotate_flip (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  srf_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output srf_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srf_pkg::PADDR_W-1:0]   paddr,
  input  logic [srf_pkg::PDATA_W-1:0]   pwdata,
  output logic [srf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import srf_pkg::*;

  logic [SIDE_CFG_W-1:0] side_r, side_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic                  resync_req_r, resync_req_nxt;
  logic                  cfg_wr;
  logic [N_W-1:0]        n_eff;
  logic                  in_fire, wr_fire, rd_fire;
  logic                  div_busy, busy;
  div_res_t              div_res;
  logic [POS_W-1:0]      wr_addr, rd_addr, div_dividend;
  logic                  rd_last;
  logic [TOT_W-1:0]      total;
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_last_r;
  logic                  s1_adv;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    side_nxt       = side_r;
    mode_nxt       = mode_r;
    resync_req_nxt = 1'b0;
    if (cfg_wr) begin
      case (paddr[2])
        REG_SIDE: begin
          side_nxt       = pwdata[SIDE_CFG_W-1:0];
          resync_req_nxt = 1'b1;
        end
        REG_MODE: mode_nxt = pwdata[MODE_W-1:0];
        default:  mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r       <= SIDE_RESET;
      mode_r       <= MODE_IDENT;
      resync_req_r <= 1'b0;
    end else begin
      side_r       <= side_nxt;
      mode_r       <= mode_nxt;
      resync_req_r <= resync_req_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE: prdata = PDATA_W'(mode_r);
      default:  prdata = PDATA_W'(side_r);
    endcase
  end

  // clamp side to 1..MAX_SIDE
  always_comb begin
    if (side_r == '0) begin
      n_eff = N_W'(1);
    end else if (side_r > MAX_SIDE) begin
      n_eff = N_W'(MAX_SIDE);
    end else begin
      n_eff = N_W'(side_r);
    end
  end

  // request handshake
  assign busy     = resync_req_r || div_busy;
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = busy || (s1_valid_r && !s1_adv);
  assign in_fire  = in_valid && !in_stall;
  assign wr_fire  = in_fire && (in_data.action == ACT_WRITE);
  assign rd_fire  = in_fire && (in_data.action == ACT_READ);

  srf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (resync_req_r),
    .dividend (div_dividend),
    .divisor  (n_eff),
    .busy     (div_busy),
    .res      (div_res)
  );

  srf_position u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .n_eff        (n_eff),
    .mode         (mode_r),
    .wr_fire      (wr_fire),
    .rd_fire      (rd_fire),
    .resync_start (resync_req_r),
    .div_res      (div_res),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .rd_last      (rd_last),
    .div_dividend (div_dividend),
    .total        (total)
  );

  srf_pixel_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_fire),
    .wr_addr (wr_addr),
    .wr_data (in_data.pixel_in),
    .rd_en   (rd_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // read stage and output register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (rd_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      s1_last_r <= rd_last;
    end
    if (s1_adv) begin
      out_data_r.pixel_out     <= rd_data;
      out_data_r.last_of_image <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_rd_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    rd_fire |=> s1_valid_r)
    else $error("read request did not reach the read stage");

  a_rd_addr_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    rd_fire |-> ({1'b0, rd_addr} < total))
    else $error("source address outside the image");

  a_no_accept_in_resync: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> $past(div_busy) && !in_fire)
    else $error("request accepted while row and column were rebuilt");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r && $stable(rd_data))
    else $error("blocked read stage lost its data");

endmodule
